### hw/rtl/dttb_pkg.sv
// ----------------------------------------------------------------------------
// dttb_pkg
// Shared types, constants and helpers for the draft token trie builder.
// ----------------------------------------------------------------------------
package dttb_pkg;

	localparam int MAX_NODES_DEF  = 64;
	localparam int TOKEN_BITS_DEF = 20;

	localparam int TOKEN_IN_W  = 20;
	localparam int IDX_OUT_W   = 6;
	localparam int LIMIT_W     = 6;
	localparam int DATA_W      = 24;
	localparam int USER_W      = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd16;

	localparam logic OP_CLEAR  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic start;
		logic wr_en;
	} scan_ctrl_t;

	// outcome of a scan, valid for one cycle
	typedef struct packed {
		logic hit;
		logic miss;
	} scan_status_t;

	// result word: node, parent, created, dropped, count from bit 0 up
	function automatic logic [DATA_W-1:0] pack_result(
		input logic [IDX_OUT_W-1:0] node,
		input logic [IDX_OUT_W-1:0] parent,
		input logic                 created,
		input logic                 dropped,
		input logic [IDX_OUT_W-1:0] count
	);
		logic [DATA_W-1:0] word;
		word = '0;
		word[IDX_OUT_W-1:0]             = node;
		word[2*IDX_OUT_W-1:IDX_OUT_W]   = parent;
		word[2*IDX_OUT_W]               = created;
		word[2*IDX_OUT_W+1]             = dropped;
		word[3*IDX_OUT_W+1:2*IDX_OUT_W+2] = count;
		return word;
	endfunction

endpackage

### hw/rtl/dttb_scan_unit.sv
// ----------------------------------------------------------------------------
// dttb_scan_unit
// Node store plus one comparator; walks nodes 1..used looking for a child of
// the given parent with the given token, one node per cycle.
// ----------------------------------------------------------------------------
module dttb_scan_unit #(
	parameter int MaxNodes  = dttb_pkg::MAX_NODES_DEF,
	parameter int TokenBits = dttb_pkg::TOKEN_BITS_DEF,
	parameter int NodeW     = $clog2(MaxNodes)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dttb_pkg::scan_ctrl_t   ctrl,
	input  logic [NodeW-1:0]       used,
	input  logic [NodeW-1:0]       parent,
	input  logic [TokenBits-1:0]   key,
	input  logic [NodeW-1:0]       wr_idx,
	output dttb_pkg::scan_status_t status,
	output logic [NodeW-1:0]       hit_idx
);

	localparam int EntW = NodeW + TokenBits;

	logic [EntW-1:0]  mem [MaxNodes];
	logic [EntW-1:0]  rd_s1;
	logic [NodeW-1:0] cmp_idx_s1;
	logic             cmp_vld_s1;
	logic [NodeW:0]   iss_q;
	logic             active_q;
	logic             issue;
	logic             match;

	assign issue = active_q && (iss_q <= {1'b0, used});
	assign match = cmp_vld_s1 && (rd_s1 == {parent, key});

	assign status.hit  = active_q && match;
	assign status.miss = active_q && !issue && !match;
	assign hit_idx     = cmp_idx_s1;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_idx] <= {parent, key};
		end
	end

	always_ff @(posedge clk) begin
		rd_s1      <= mem[iss_q[NodeW-1:0]];
		cmp_idx_s1 <= iss_q[NodeW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q      <= '0;
			active_q   <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else if (ctrl.start) begin
			iss_q      <= (NodeW+1)'(1);
			active_q   <= 1'b1;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue) begin
				iss_q <= iss_q + (NodeW+1)'(1);
			end
			if (status.hit || status.miss) begin
				active_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_hit_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.hit && status.miss))
		else $error("scan reports hit and miss together");

	a_hit_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		status.hit |-> (hit_idx != '0))
		else $error("scan hit on root index");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(status.hit || status.miss) |=> !active_q || $past(ctrl.start))
		else $error("scan still active after finishing");
`endif

endmodule

### hw/rtl/draft_token_trie_builder.sv
// A clear or a dropped token passes through the result register, then the output register;
// an insert first scans the stored nodes, so it takes longer the more nodes are in use.
// The node scan compares one stored node per cycle through one memory port.
// A new input is taken once the previous result is handed to the output register.
// Reset (arst_n low): empty tree, walk at root, draft_limit = 16; store not cleared.
// ----------------------------------------------------------------------------
// draft_token_trie_builder
// Builds a bounded prefix trie from a token stream; one result per input.
// ----------------------------------------------------------------------------
module draft_token_trie_builder #(
	parameter int MAX_NODES  = dttb_pkg::MAX_NODES_DEF,
	parameter int TOKEN_BITS = dttb_pkg::TOKEN_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dttb_pkg::DATA_W-1:0]     s_tdata,  // token
	input  logic [dttb_pkg::USER_W-1:0]     s_tuser,  // operation, path_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// node_index, parent_index, created, dropped, node_count
	output logic [dttb_pkg::DATA_W-1:0]     m_tdata,
	input  logic                            cfg_wr_en,
	input  logic [dttb_pkg::LIMIT_W-1:0]    cfg_wr_data
);

	localparam int NodeW = $clog2(MAX_NODES);
	localparam int CmpW  = (NodeW > dttb_pkg::LIMIT_W) ? NodeW : dttb_pkg::LIMIT_W;
	localparam logic [NodeW-1:0] LastIdx = NodeW'(MAX_NODES - 1);
	localparam int OutW  = dttb_pkg::IDX_OUT_W;

	dttb_pkg::state_t       state_q, state_d;
	dttb_pkg::scan_ctrl_t   scan_ctrl;
	dttb_pkg::scan_status_t scan_status;

	logic [dttb_pkg::LIMIT_W-1:0] limit_q;
	logic [NodeW-1:0]             used_q, used_d;
	logic [NodeW-1:0]             cur_q, cur_d;
	logic [NodeW-1:0]             parent_q, parent_d;
	logic [TOKEN_BITS-1:0]        key_q, key_d;
	logic [dttb_pkg::DATA_W-1:0]  res_q, res_d;
	logic [dttb_pkg::DATA_W-1:0]  out_q;
	logic                         out_vld_q;
	logic                         out_load;
	logic [NodeW-1:0]             hit_idx;
	logic [NodeW-1:0]             new_idx;
	logic                         in_fire;
	logic                         full;

	assign in_fire = s_tvalid && s_tready;
	assign new_idx = used_q + NodeW'(1);
	assign full    = (CmpW'(used_q) >= CmpW'(limit_q)) || (used_q == LastIdx);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	dttb_scan_unit #(
		.MaxNodes  (MAX_NODES),
		.TokenBits (TOKEN_BITS),
		.NodeW     (NodeW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (scan_ctrl),
		.used    (used_q),
		.parent  (parent_q),
		.key     (key_q),
		.wr_idx  (new_idx),
		.status  (scan_status),
		.hit_idx (hit_idx)
	);

	always_comb begin
		state_d         = state_q;
		used_d          = used_q;
		cur_d           = cur_q;
		parent_d        = parent_q;
		key_d           = key_q;
		res_d           = res_q;
		s_tready        = 1'b0;
		out_load        = 1'b0;
		scan_ctrl.start = 1'b0;
		scan_ctrl.wr_en = 1'b0;
		unique case (state_q)
			dttb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (in_fire) begin
					state_d = dttb_pkg::ST_DONE;
					if (s_tuser[0] == dttb_pkg::OP_CLEAR) begin
						used_d = '0;
						cur_d  = '0;
						res_d  = '0;
					end else if (full) begin
						res_d = dttb_pkg::pack_result('0, '0, 1'b0, 1'b1, OutW'(used_q));
					end else begin
						parent_d        = s_tuser[1] ? '0 : cur_q;
						cur_d           = parent_d;
						key_d           = TOKEN_BITS'(s_tdata[dttb_pkg::TOKEN_IN_W-1:0]);
						scan_ctrl.start = 1'b1;
						state_d         = dttb_pkg::ST_SCAN;
					end
				end
			end
			dttb_pkg::ST_SCAN: begin
				if (scan_status.hit) begin
					cur_d   = hit_idx;
					res_d   = dttb_pkg::pack_result(OutW'(hit_idx), OutW'(parent_q),
						1'b0, 1'b0, OutW'(used_q));
					state_d = dttb_pkg::ST_DONE;
				end else if (scan_status.miss) begin
					scan_ctrl.wr_en = 1'b1;
					used_d  = new_idx;
					cur_d   = new_idx;
					res_d   = dttb_pkg::pack_result(OutW'(new_idx), OutW'(parent_q),
						1'b1, 1'b0, OutW'(new_idx));
					state_d = dttb_pkg::ST_DONE;
				end
			end
			dttb_pkg::ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					out_load = 1'b1;
					state_d  = dttb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dttb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dttb_pkg::ST_IDLE;
			limit_q   <= dttb_pkg::LIMIT_RESET;
			used_q    <= '0;
			cur_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			cur_q   <= cur_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		parent_q <= parent_d;
		key_q    <= key_d;
		res_q    <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_create_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dttb_pkg::ST_SCAN && scan_status.miss)
		|=> used_q == $past(used_q) + NodeW'(1))
		else $error("node count not advanced on create");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser[0] == dttb_pkg::OP_CLEAR) |=> (used_q == '0 && cur_q == '0))
		else $error("clear did not empty the tree");

	a_hit_moves_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dttb_pkg::ST_SCAN && scan_status.hit) |=> cur_q != '0)
		else $error("walk left at root after a match");

	a_no_scan_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		scan_ctrl.start |-> !full)
		else $error("scan started with tree at capacity");
`endif

endmodule
